// ===== sv/idq_pkg.sv =====
`default_nettype none

package idq_pkg;

  // fixed field widths of the channels
  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // default sizing
  localparam int DEPTH_DEF     = 1024;
  localparam int WORD_BITS_DEF = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ       = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // memory access strobes
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  // response fields other than the read word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic [DATA_W-1:0]   front_word;
    logic [DATA_W-1:0]   back_word;
    logic                rd_sel;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/idq_in_if.sv =====
`default_nettype none

interface idq_in_if;
  logic                         valid;
  logic                         ready;
  logic [idq_pkg::OP_W-1:0]     op;
  logic [idq_pkg::DATA_W-1:0]   value;
  logic [idq_pkg::INDEX_W-1:0]  index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

`default_nettype wire

// ===== sv/idq_out_if.sv =====
`default_nettype none

interface idq_out_if;
  logic                          valid;
  logic                          ready;
  logic [idq_pkg::DATA_W-1:0]    read_data;
  logic [idq_pkg::STATUS_W-1:0]  status;
  logic [idq_pkg::COUNT_W-1:0]   count;
  logic                          empty_res;
  logic [idq_pkg::DATA_W-1:0]    front_word;
  logic [idq_pkg::DATA_W-1:0]    back_word;

  modport source (output valid, output read_data, output status, output count,
                  output empty_res, output front_word, output back_word, input ready);
  modport sink   (input valid, input read_data, input status, input count,
                  input empty_res, input front_word, input back_word, output ready);
endinterface

`default_nettype wire

// ===== sv/idq_mem.sv =====
`default_nettype none

module idq_mem #(
  parameter int DEPTH     = idq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = idq_pkg::WORD_BITS_DEF,
  localparam int PTR_W    = $clog2(DEPTH)
) (
  input  wire                      clk_i,
  input  wire idq_pkg::mem_cmd_t   cmd_i,
  input  wire [PTR_W-1:0]          addr_i,
  input  wire [WORD_BITS-1:0]      wdata_i,
  output logic [WORD_BITS-1:0]     rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  // single port, write or registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/idq_ctrl.sv =====
`default_nettype none

module idq_ctrl #(
  parameter int DEPTH     = idq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = idq_pkg::WORD_BITS_DEF,
  localparam int PTR_W    = $clog2(DEPTH)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               acc_i,
  input  wire [idq_pkg::OP_W-1:0]           op_i,
  input  wire [idq_pkg::DATA_W-1:0]         value_i,
  input  wire [idq_pkg::INDEX_W-1:0]        index_i,
  output idq_pkg::mem_cmd_t                 cmd_o,
  output logic [PTR_W-1:0]                  addr_o,
  output logic [WORD_BITS-1:0]              wdata_o,
  output idq_pkg::res_t                     res_o
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = PTR_W + 1;
  localparam int CMP_W  = (CNT_W > idq_pkg::INDEX_W) ? CNT_W : idq_pkg::INDEX_W;
  localparam int OW     = idq_pkg::DATA_W;
  localparam int CW     = idq_pkg::COUNT_W;

  logic [PTR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [WORD_BITS-1:0] front_q, front_d;
  logic [WORD_BITS-1:0] back_q, back_d;

  logic                 is_push, is_read, full, in_range, do_push;
  logic [WORD_BITS-1:0] val_w;
  logic [CMP_W-1:0]     idx_cmp;
  logic [SLOT_W-1:0]    rd_sum, bk_sum;
  logic [PTR_W-1:0]     rd_slot, bk_slot, fr_slot;

  // decode and bounds
  assign is_push  = (op_i == idq_pkg::OP_PUSH_FRONT) || (op_i == idq_pkg::OP_PUSH_BACK);
  assign is_read  = (op_i == idq_pkg::OP_READ);
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign idx_cmp  = CMP_W'(index_i);
  assign in_range = (idx_cmp < CMP_W'(cnt_q));
  assign do_push  = is_push && !full;
  assign val_w    = WORD_BITS'(value_i);

  // circular slot arithmetic, sums stay below twice the depth
  assign rd_sum  = SLOT_W'(head_q) + SLOT_W'(idx_cmp[PTR_W-1:0]);
  assign rd_slot = (rd_sum >= SLOT_W'(DEPTH)) ? PTR_W'(rd_sum - SLOT_W'(DEPTH))
                                              : rd_sum[PTR_W-1:0];
  assign bk_sum  = SLOT_W'(head_q) + SLOT_W'(cnt_q[PTR_W-1:0]);
  assign bk_slot = (bk_sum >= SLOT_W'(DEPTH)) ? PTR_W'(bk_sum - SLOT_W'(DEPTH))
                                              : bk_sum[PTR_W-1:0];
  assign fr_slot = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);

  // memory request
  always_comb begin
    cmd_o.wr = acc_i && do_push;
    cmd_o.rd = acc_i && is_read && in_range;
    wdata_o  = val_w;
    case (op_i)
      idq_pkg::OP_PUSH_FRONT: addr_o = fr_slot;
      idq_pkg::OP_PUSH_BACK:  addr_o = bk_slot;
      default:                addr_o = rd_slot;
    endcase
  end

  // next pointer, count and end words
  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    front_d = front_q;
    back_d  = back_q;
    if (do_push) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (op_i == idq_pkg::OP_PUSH_FRONT) begin
        head_d  = fr_slot;
        front_d = val_w;
        if (cnt_q == '0) begin
          back_d = val_w;
        end
      end else begin
        back_d = val_w;
        if (cnt_q == '0) begin
          front_d = val_w;
        end
      end
    end
  end

  // response fields
  always_comb begin
    if (is_push && full) begin
      res_o.status = idq_pkg::ST_FULL;
    end else if (is_read && !in_range) begin
      res_o.status = idq_pkg::ST_RANGE;
    end else begin
      res_o.status = idq_pkg::ST_OK;
    end
    res_o.count      = CW'(cnt_d);
    res_o.empty      = (cnt_d == '0);
    res_o.front_word = (cnt_d == '0) ? '0 : OW'(front_d);
    res_o.back_word  = (cnt_d == '0) ? '0 : OW'(back_d);
    res_o.rd_sel     = is_read && in_range;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else if (acc_i) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // cached end words
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && is_push && full |=> cnt_q == $past(cnt_q) && head_q == $past(head_q))
    else $error("dropped push changed state");

  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("store write without count step");

  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> !cmd_o.wr && CMP_W'(index_i) < CMP_W'(cnt_q))
    else $error("store read outside held words");
`endif

endmodule

`default_nettype wire

// ===== sv/indexed_deque.sv =====
// indexed_deque: double-ended queue of data words with read by position
// req_i carries op (push front, push back, read), value and index; an item
// is taken on a clock edge with valid and ready high
// rsp_o returns one response per request: read word, status (ok, position
// out of range, store full), count after the request, empty flag and the
// front and back words (zero when empty)
// words sit in a single-port circular memory; front and back words are
// cached in registers so each request needs at most one memory access
// the response is registered and valid in the cycle after the request is taken
// throughput: one request per cycle while responses are taken, as a request
// makes at most one memory access; the read word comes from the memory's registered read port
// when the receiver stalls, the response register holds and a new request is
// taken only in the cycle the held response is taken
// reset clears the head pointer, count and response valid; the memory needs
// no clearing, only written slots are ever read
`default_nettype none

module indexed_deque #(
  parameter int DEPTH     = idq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = idq_pkg::WORD_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  idq_in_if.sink     req_i,
  idq_out_if.source  rsp_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OW    = idq_pkg::DATA_W;

  logic                 acc;
  logic                 rsp_valid_q;
  idq_pkg::res_t        res_d, res_q;
  idq_pkg::mem_cmd_t    cmd;
  logic [PTR_W-1:0]     addr;
  logic [WORD_BITS-1:0] wdata, rdata;

  // request accepted when the response slot is free or being drained
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  idq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .op_i    (req_i.op),
    .value_i (req_i.value),
    .index_i (req_i.index),
    .cmd_o   (cmd),
    .addr_o  (addr),
    .wdata_o (wdata),
    .res_o   (res_d)
  );

  idq_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (acc) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // response fields
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_data  = res_q.rd_sel ? OW'(rdata) : '0;
  assign rsp_o.status     = res_q.status;
  assign rsp_o.count      = res_q.count;
  assign rsp_o.empty_res  = res_q.empty;
  assign rsp_o.front_word = res_q.front_word;
  assign rsp_o.back_word  = res_q.back_word;

`ifndef SYNTHESIS
  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |-> !acc)
    else $error("request taken over a held response");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_valid_q)
    else $error("response missing after request");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |=> $stable(rsp_o.read_data))
    else $error("read word changed while stalled");
`endif

endmodule

`default_nettype wire
